### rtl/egbw_pkg.sv
// ----------------------------------------------------------------------------
// egbw_pkg
// Shared types and constants of the Exp-Golomb bitstream writer.
// ----------------------------------------------------------------------------
package egbw_pkg;

    localparam int FIELD_BITS = 32;            // longest fixed field u(n)
    localparam int CODE_W     = 32;            // code word, left aligned
    localparam int LEN_W      = 6;             // code length 0..32
    localparam int ACC_W      = CODE_W + 8;    // packing register
    localparam int UE_W       = 16;            // ue value after saturation
    localparam logic [UE_W-1:0] UE_MAX = 16'd65534;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
    localparam int IDX_W      = 16;
    localparam int IN_DATA_W  = 56;            // 54 bits of fields, padded
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        OP_FIXED  = 2'd0,
        OP_UE     = 2'd1,
        OP_SE     = 2'd2,
        OP_FINISH = 2'd3
    } t_opcode;

    // one classified element as it travels through the queue
    typedef struct packed {
        logic [CODE_W-1:0] code;   // MSB aligned to bit CODE_W-1
        logic [LEN_W-1:0]  len;
        logic              fin;
    } t_elem;

    typedef struct packed {
        logic [LEN_W-1:0] pend_bits;
        logic [IDX_W-1:0] byte_cnt;
        logic             pop;
    } t_back_stat;

endpackage

### rtl/egbw_front.sv
// ----------------------------------------------------------------------------
// egbw_front
// Classifies one syntax element into a left-aligned code word and a length.
// ----------------------------------------------------------------------------
module egbw_front (
    input  logic [1:0]              i_opcode,
    input  logic [5:0]              i_bit_count,
    input  logic [31:0]             i_value_unsigned,
    input  logic signed [15:0]      i_value_signed,
    output egbw_pkg::t_elem         o_elem
);
    import egbw_pkg::*;

    logic [LEN_W-1:0]   fix_len;
    logic [CODE_W-1:0]  fix_code;
    logic signed [15:0] s_clamp;
    logic [15:0]        s_neg;
    logic [UE_W-1:0]    se_map;
    logic [UE_W-1:0]    ue_v;
    logic [UE_W-1:0]    ue_x;
    logic [3:0]         ue_m;
    logic [4:0]         ue_sh;
    logic [CODE_W-1:0]  ue_code;
    logic [LEN_W-1:0]   ue_len;

    always_comb begin
        fix_len  = (i_bit_count > LEN_W'(FIELD_BITS)) ? LEN_W'(FIELD_BITS) : i_bit_count;
        // shift by 32 for a zero-length field clears everything
        fix_code = i_value_unsigned << (LEN_W'(CODE_W) - fix_len);
    end

    // se(v): v > 0 -> 2v-1, v <= 0 -> -2v; the most negative value folds in
    always_comb begin
        s_clamp = (i_value_signed == 16'sh8000) ? -16'sd32767 : i_value_signed;
        s_neg   = 16'(-s_clamp);
        if (s_clamp > 16'sd0) begin
            se_map = {s_clamp[14:0], 1'b0} - 16'd1;
        end else begin
            se_map = {s_neg[14:0], 1'b0};
        end
    end

    always_comb begin
        if (t_opcode'(i_opcode) == OP_SE) begin
            ue_v = se_map;
        end else if (i_value_unsigned > {16'd0, UE_MAX}) begin
            ue_v = UE_MAX;
        end else begin
            ue_v = i_value_unsigned[UE_W-1:0];
        end
        ue_x = ue_v + 16'd1;
        // leading-one detect
        ue_m = '0;
        for (int i = 0; i < UE_W; i++) begin
            if (ue_x[i]) begin
                ue_m = 4'(i);
            end
        end
        ue_sh   = 5'd31 - {ue_m, 1'b0};
        ue_code = {16'd0, ue_x} << ue_sh;
        ue_len  = LEN_W'({ue_m, 1'b0}) + LEN_W'(1);
    end

    always_comb begin
        o_elem = '0;
        case (t_opcode'(i_opcode))
            OP_FIXED: begin
                o_elem.code = fix_code;
                o_elem.len  = fix_len;
            end
            OP_UE, OP_SE: begin
                o_elem.code = ue_code;
                o_elem.len  = ue_len;
            end
            OP_FINISH: begin
                o_elem.fin = 1'b1;
            end
            default: begin
                o_elem = '0;
            end
        endcase
    end

endmodule

### rtl/egbw_queue.sv
// ----------------------------------------------------------------------------
// egbw_queue
// Short queue of classified elements between the front and the packer.
// ----------------------------------------------------------------------------
module egbw_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  egbw_pkg::t_elem                 i_elem,
    output logic                            o_full,
    input  logic                            i_pop,
    output logic                            o_valid,
    output egbw_pkg::t_elem                 o_elem,
    output logic [egbw_pkg::Q_CNT_W-1:0]    o_count
);
    import egbw_pkg::*;

    t_elem               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic [Q_PTR_W-1:0]  n_wr_ptr;
    logic [Q_PTR_W-1:0]  n_rd_ptr;
    logic [Q_CNT_W-1:0]  n_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_elem  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + Q_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + Q_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### rtl/egbw_back.sv
// ----------------------------------------------------------------------------
// egbw_back
// Bit packer: merges code words into the bit register and emits bytes.
// ----------------------------------------------------------------------------
module egbw_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  egbw_pkg::t_elem                 i_q_elem,
    output logic                            o_q_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_out_byte,
    output logic [egbw_pkg::IDX_W-1:0]      o_out_index,
    output logic                            o_out_last,
    output egbw_pkg::t_back_stat            o_stat
);
    import egbw_pkg::*;

    // pending bits sit MSB-aligned in r_acc; bits below r_cnt are zero
    logic [ACC_W-1:0]  r_acc;
    logic [LEN_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_byte_cnt;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic [IDX_W-1:0]  r_out_index;
    logic              r_out_last;

    logic [ACC_W-1:0]  n_acc;
    logic [LEN_W-1:0]  n_cnt;
    logic [IDX_W-1:0]  n_byte_cnt;
    logic              n_out_valid;
    logic [7:0]        n_out_byte;
    logic [IDX_W-1:0]  n_out_index;
    logic              n_out_last;

    logic              can_out;
    logic              pop;
    logic [ACC_W-1:0]  merged;
    logic [LEN_W-1:0]  m_cnt;
    logic              emit;
    logic [IDX_W-1:0]  cnt_inc;

    assign can_out = !r_out_valid || i_out_ready;
    assign pop     = can_out && (r_cnt < LEN_W'(8)) && i_q_valid;
    assign merged  = r_acc | ({i_q_elem.code, 8'd0} >> r_cnt[2:0]);
    assign m_cnt   = r_cnt + i_q_elem.len;
    assign cnt_inc = (r_byte_cnt == '1) ? r_byte_cnt : r_byte_cnt + IDX_W'(1);

    always_comb begin
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_byte_cnt  = r_byte_cnt;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_index = r_out_index;
        n_out_last  = r_out_last;
        emit        = 1'b0;
        if (can_out) begin
            n_out_valid = 1'b0;
            if (r_cnt >= LEN_W'(8)) begin
                emit       = 1'b1;
                n_out_byte = r_acc[ACC_W-1 -: 8];
                n_out_last = 1'b0;
                n_acc      = r_acc << 8;
                n_cnt      = r_cnt - LEN_W'(8);
                n_byte_cnt = cnt_inc;
            end else if (i_q_valid) begin
                if (i_q_elem.fin) begin
                    // stop bit then zero fill; position and count restart
                    emit       = 1'b1;
                    n_out_byte = r_acc[ACC_W-1 -: 8] | (8'h80 >> r_cnt[2:0]);
                    n_out_last = 1'b1;
                    n_acc      = '0;
                    n_cnt      = '0;
                    n_byte_cnt = '0;
                end else if (m_cnt >= LEN_W'(8)) begin
                    emit       = 1'b1;
                    n_out_byte = merged[ACC_W-1 -: 8];
                    n_out_last = 1'b0;
                    n_acc      = merged << 8;
                    n_cnt      = m_cnt - LEN_W'(8);
                    n_byte_cnt = cnt_inc;
                end else begin
                    n_acc = merged;
                    n_cnt = m_cnt;
                end
            end
            if (emit) begin
                n_out_valid = 1'b1;
                n_out_index = r_byte_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_byte_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_byte_cnt  <= n_byte_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte  <= n_out_byte;
        r_out_index <= n_out_index;
        r_out_last  <= n_out_last;
    end

    assign o_q_pop          = pop;
    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_out_index      = r_out_index;
    assign o_out_last       = r_out_last;
    assign o_stat.pend_bits = r_cnt;
    assign o_stat.byte_cnt  = r_byte_cnt;
    assign o_stat.pop       = pop;

endmodule

### rtl/exp_golomb_bitstream_writer_core.sv
// ----------------------------------------------------------------------------
// exp_golomb_bitstream_writer_core
// H.264 header bit writer: u(n), ue(v), se(v) and rbsp trailing bits.
// ----------------------------------------------------------------------------
// Input channel (s): one syntax element per item. tuser carries the opcode,
// tdata the bit count, the unsigned value and the signed value.
// Output channel (m): one bitstream byte per item with its index in the
// current NAL; tlast marks the byte written by a finish element.
// The front classifies each element into a code word and length in the
// accepting cycle and writes it into a 4-entry queue. The packer takes one
// element per cycle from the queue and emits one byte per cycle into an
// output register while that register is free; an element producing more
// than one byte keeps the queue waiting until fewer than eight bits are
// pending. The single byte output port sets the sustained rate. With an
// empty queue, a first byte passes through the queue and the output register.
// A stalled receiver holds the output register; the packer stops and the
// queue fills, after which s_tready drops. Reset empties the queue and
// clears the partial byte, bit position and byte counter.
// ----------------------------------------------------------------------------
module exp_golomb_bitstream_writer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [5:0] bit_count, [37:6] value_unsigned, [53:38] value_signed
    input  logic [egbw_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // [1:0] opcode
    input  logic [1:0]                          i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [7:0] out_byte, [23:8] byte_index
    output logic [egbw_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tlast
);
    import egbw_pkg::*;

    t_elem               front_elem;
    t_elem               q_elem;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    logic [Q_CNT_W-1:0]  q_count;
    logic                push;
    t_back_stat          back_stat;
    logic [7:0]          out_byte;
    logic [IDX_W-1:0]    out_index;

    assign o_s_tready = !q_full;
    assign push       = i_s_tvalid && !q_full;

    egbw_front u_front (
        .i_opcode         (i_s_tuser),
        .i_bit_count      (i_s_tdata[5:0]),
        .i_value_unsigned (i_s_tdata[37:6]),
        .i_value_signed   (i_s_tdata[53:38]),
        .o_elem           (front_elem)
    );

    egbw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_elem  (front_elem),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_elem  (q_elem),
        .o_count (q_count)
    );

    egbw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_elem    (q_elem),
        .o_q_pop     (q_pop),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_byte  (out_byte),
        .o_out_index (out_index),
        .o_out_last  (o_m_tlast),
        .o_stat      (back_stat)
    );

    assign o_m_tdata = {out_index, out_byte};

    // packer never holds more than a partial byte plus one full code word
    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.pend_bits <= LEN_W'(ACC_W - 1))
        else $error("pending bit count out of range");

    // no new element merged while a whole byte is still waiting
    a_no_pop_full_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.pend_bits >= LEN_W'(8) |-> !back_stat.pop)
        else $error("element popped with a whole byte pending");

    // while the finish byte is shown, the NAL state has already restarted
    a_finish_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> back_stat.pend_bits == '0 && back_stat.byte_cnt == '0)
        else $error("state not restarted after finish");

    // queue occupancy never exceeds its depth
    a_queue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue occupancy out of range");

    // an accepted element that is not popped leaves the queue non-empty
    a_queue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !q_pop |=> q_count != '0)
        else $error("queue occupancy inconsistent");

endmodule

### dv/exp_golomb_bitstream_writer_core_tb.sv
// ----------------------------------------------------------------------------
// exp_golomb_bitstream_writer_core_tb
// Self-checking bench for the u(n)/ue(v)/se(v)/trailing-bits stream packer.
// Each accepted element is run through a local bit packer. The bytes it
// predicts are compared in order with the stream that the core emits. Both
// sides idle at random.
// ----------------------------------------------------------------------------
module exp_golomb_bitstream_writer_core_tb;

    import egbw_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SE_LIM      = 32767;
    localparam int MAX_REPORTS = 10;

    // one syntax element; packed MSB first in the order below
    typedef struct packed {
        t_opcode            op;
        logic [5:0]         nbits;
        logic [31:0]        uval;
        logic signed [15:0] sval;
    } t_element;

    typedef struct packed {
        logic [7:0]  octet;
        logic [15:0] idx;
        logic        last;
    } t_stream_byte;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [1:0]            s_tuser  = 2'b00;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    t_element     element_q[$];     // elements waiting to be sent
    t_stream_byte bitstream_q[$];   // predicted output bytes, oldest first
    t_element     drv_elem;
    t_stream_byte want;

    // packer state of the prediction
    logic [7:0]  acc_byte  = '0;
    int          bit_pos   = 0;
    logic [15:0] nal_count = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycles        = 0;
    int errors        = 0;
    int n_elements    = 0;
    int n_bytes       = 0;
    int n_nals        = 0;
    int n_sat_bytes   = 0;

    always #6 i_clk = ~i_clk;

    exp_golomb_bitstream_writer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic void emit_octet(input logic [7:0] octet, input logic last);
        bitstream_q.push_back('{octet: octet, idx: nal_count, last: last});
        if (nal_count != 16'hFFFF) begin
            nal_count++;
        end
    endfunction

    // append the low n bits of val, MSB first
    function automatic void shift_bits(input logic [39:0] val, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            if (val[i]) begin
                acc_byte[7 - bit_pos] = 1'b1;
            end
            bit_pos++;
            if (bit_pos == 8) begin
                emit_octet(acc_byte, 1'b0);
                acc_byte = '0;
                bit_pos  = 0;
            end
        end
    endfunction

    // m leading zeros, then the m+1 bits of v+1
    function automatic void put_ue(input logic [31:0] v);
        int x;
        int t;
        int m;
        if (v > UE_MAX) begin
            v = UE_MAX;
        end
        x = int'(v) + 1;
        t = x;
        m = 0;
        while (t > 1) begin
            t = t >> 1;
            m++;
        end
        shift_bits(40'(x), 2 * m + 1);
    endfunction

    function automatic void encode_element(input t_element e);
        int nb;
        int v;
        case (e.op)
            OP_FIXED: begin
                nb = (e.nbits > FIELD_BITS) ? FIELD_BITS : int'(e.nbits);
                shift_bits({8'd0, e.uval}, nb);
            end
            OP_UE: begin
                put_ue(e.uval);
            end
            OP_SE: begin
                v = e.sval;
                if (v < -SE_LIM) begin
                    v = -SE_LIM;
                end
                if (v > 0) begin
                    put_ue(32'(2 * v - 1));
                end else begin
                    put_ue(32'(-2 * v));
                end
            end
            default: begin
                acc_byte[7 - bit_pos] = 1'b1;
                emit_octet(acc_byte, 1'b1);
                acc_byte  = '0;
                bit_pos   = 0;
                nal_count = '0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic void push_elem(input t_opcode op, input logic [5:0] nbits,
                                      input logic [31:0] uval, input logic [15:0] sval);
        element_q.push_back('{op: op, nbits: nbits, uval: uval, sval: sval});
    endfunction

    // all fields are filled every time: unused ones must be ignored
    function automatic t_element random_element();
        t_element e;
        int r;
        r = $urandom_range(99);
        if (r < 35) begin
            e.op = OP_FIXED;
        end else if (r < 60) begin
            e.op = OP_UE;
        end else if (r < 85) begin
            e.op = OP_SE;
        end else begin
            e.op = OP_FINISH;
        end
        e.nbits = ($urandom_range(9) < 7) ? 6'($urandom_range(32)) : 6'($urandom_range(63));
        e.uval  = $urandom();
        case ($urandom_range(3))
            0: e.uval = $urandom_range(15);
            1: e.uval = $urandom_range(4095);
            2: e.uval = $urandom_range(65540, 65525);
            default: ;
        endcase
        case ($urandom_range(3))
            0: e.sval = 16'($urandom_range(32) - 16);
            1: e.sval = 16'($urandom_range(65535));
            2: e.sval = ($urandom_range(1) != 0) ? 16'sh8000 : 16'sh7FFF;
            default: e.sval = 16'($urandom_range(2000) - 1000);
        endcase
        return e;
    endfunction

    task automatic wait_drained();
        while (element_q.size() != 0 || s_tvalid) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase 1: slow receiver
        send_idle_pct = 19;
        recv_idle_pct = 88;
        push_elem(OP_FIXED,  6'd0,  32'hFFFF_FFFF, 16'h1234);  // writes nothing
        push_elem(OP_FIXED,  6'd1,  32'h0000_0001, 16'h0000);
        push_elem(OP_FIXED,  6'd32, 32'hFFFF_FFFF, 16'hFFFF);
        push_elem(OP_FIXED,  6'd63, 32'hA5A5_A5A5, 16'h0000);  // clamped to 32
        push_elem(OP_FIXED,  6'd33, 32'h1234_5678, 16'h0000);
        push_elem(OP_FIXED,  6'd32, 32'h0000_0000, 16'h0000);
        push_elem(OP_UE,     6'd63, 32'd0,         16'h7FFF);
        push_elem(OP_UE,     6'd0,  32'd1,         16'h0000);
        push_elem(OP_UE,     6'd0,  32'd2,         16'h0000);
        push_elem(OP_UE,     6'd0,  32'd65534,     16'h0000);
        push_elem(OP_UE,     6'd0,  32'd65535,     16'h0000);  // saturates
        push_elem(OP_UE,     6'd0,  32'hFFFF_FFFF, 16'h0000);
        push_elem(OP_SE,     6'd32, 32'hFFFF_FFFF, 16'sd0);
        push_elem(OP_SE,     6'd0,  32'd0,         16'sd1);
        push_elem(OP_SE,     6'd0,  32'd0,         -16'sd1);
        push_elem(OP_SE,     6'd0,  32'd0,         16'sd32767);
        push_elem(OP_SE,     6'd0,  32'd0,         -16'sd32767);
        push_elem(OP_SE,     6'd0,  32'd0,         16'sh8000);  // taken as -32767
        push_elem(OP_FINISH, 6'd63, 32'hFFFF_FFFF, 16'hFFFF);   // unaligned
        push_elem(OP_FINISH, 6'd0,  32'd0,         16'h0000);   // aligned: 0x80
        push_elem(OP_FIXED,  6'd8,  32'h0000_003C, 16'h0000);
        push_elem(OP_FINISH, 6'd0,  32'd0,         16'h0000);   // aligned after a byte
        push_elem(OP_FIXED,  6'd7,  32'h0000_007F, 16'h0000);
        push_elem(OP_FINISH, 6'd0,  32'd0,         16'h0000);   // fills the last bit
        repeat (56) element_q.push_back(random_element());
        wait_drained();

        // phase 2: slow sender
        send_idle_pct = 88;
        recv_idle_pct = 19;
        repeat (60) element_q.push_back(random_element());
        wait_drained();

        // phase 3: full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (50) element_q.push_back(random_element());
        push_elem(OP_FINISH, 6'd0, 32'd0, 16'h0000);
        repeat (5) element_q.push_back(random_element());
        push_elem(OP_FIXED, 6'd3, 32'h5, 16'h0000);
        push_elem(OP_FINISH, 6'd0, 32'd0, 16'h0000);
        wait_drained();

        while (bitstream_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("covered %0d elements of all four kinds, %0d NALs closed, %0d bytes compared",
                 n_elements, n_nals, n_bytes);
        $display("%0d bytes carried the saturated index, %0d mismatches",
                 n_sat_bytes, errors);
        if (errors == 0 && bitstream_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (element_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_elem = element_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drv_elem.op;
                s_tdata  <= {2'b00, drv_elem.sval, drv_elem.uval, drv_elem.nbits};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on input accept, checks on output accept
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                n_elements++;
                if (t_opcode'(s_tuser) == OP_FINISH) begin
                    n_nals++;
                end
                encode_element(t_element'({s_tuser, s_tdata[5:0], s_tdata[37:6],
                                           s_tdata[53:38]}));
            end
            if (m_tvalid && m_tready) begin
                n_bytes++;
                if (bitstream_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("unexpected byte %02h idx %0d last %0b",
                                 m_tdata[7:0], m_tdata[23:8], m_tlast);
                    end
                end else begin
                    want = bitstream_q.pop_front();
                    if (want.idx == 16'hFFFF) begin
                        n_sat_bytes++;
                    end
                    if (m_tdata[7:0] != want.octet || m_tdata[23:8] != want.idx
                            || m_tlast != want.last) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display({"byte mismatch: exp %02h idx %0d last %0b,",
                                      " got %02h idx %0d last %0b"},
                                     want.octet, want.idx, want.last,
                                     m_tdata[7:0], m_tdata[23:8], m_tlast);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout: %0d bytes still expected", bitstream_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
